@@ rtl/tss_pkg.sv @@
// Shared types, constants and helpers for the tag-safe text segmenter.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

    // Text store depth; it holds at most BUF_DEPTH-1 bytes.
    localparam int BUF_DEPTH = 64;
    localparam int CNT_W     = $clog2(BUF_DEPTH);

    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt FILL_MAX = t_cnt'(BUF_DEPTH - 1);

    // Bytes kept in the trailing window: the marker length less one.
    localparam logic [2:0] WIN_LEN = 3'd4;

    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;

    typedef enum logic [2:0] {
        CMD_BYTE      = 3'd0,
        CMD_BYTE_END  = 3'd1,
        CMD_CHUNK_END = 3'd2,
        CMD_EOS       = 3'd3,
        CMD_DISCARD   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_REL,
        S_DONE
    } t_state;

    // Verdict of one scan pass over the store.
    typedef struct packed {
        logic mark;
        t_cnt len;
    } t_scan_res;

    // Circular address: a + b, wrapped at the store depth.
    function automatic t_cnt addr_add(input t_cnt a, input t_cnt b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (CNT_W+1)'(BUF_DEPTH)) begin
            s = s - (CNT_W+1)'(BUF_DEPTH);
        end
        return s[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/tag_safe_text_segmenter.sv @@
// Tag-safe text segmenter. Text words (command 0, or 1 which also ends a
// chunk) are appended to a circular 64-entry byte store; zero bytes, bytes
// beyond 63 held, and bytes after the end marker are dropped. At a chunk
// end the store is read out once, one byte per cycle, to find the "!END!"
// marker, the last '<' with no later '>' and a tail that begins the marker.
// The chosen prefix is then released as one segment. The store's single
// registered read port feeds one output register, so a byte is read only
// after the last one has landed and while that register is free. If the
// marker was found, the bytes before it are released, then a done word,
// and the store is emptied and text is ignored until end of stream or
// discard. End of stream releases all held bytes and a done word unless
// the marker was already seen. run_last marks the final word caused by one
// input word. The input is stalled while a chunk end or end of stream is
// being worked off; a finished word may wait in the output register while
// the next input word is taken.
`timescale 1ns / 1ps
`default_nettype none

module tag_safe_text_segmenter (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_in_command,
    input  wire logic [7:0] i_in_data_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_out_kind,
    output logic [7:0]      o_out_text_byte,
    output logic            o_out_segment_last,
    output logic            o_out_run_last
);
    import tss_pkg::*;

    t_state r_state, n_state;

    t_cnt r_head, n_head;
    t_cnt r_fill, n_fill;
    logic r_end_seen, n_end_seen;
    t_cnt r_idx, n_idx;
    t_cnt r_len, n_len;
    logic r_done_after, n_done_after;
    logic r_keep, n_keep;
    logic r_rd_vld, n_rd_vld;
    logic r_rd_last, n_rd_last;
    t_cnt r_rd_pos, n_rd_pos;

    logic       r_out_valid, n_out_valid;
    logic       r_out_kind, n_out_kind;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_seg, n_out_seg;
    logic       r_out_run, n_out_run;

    logic       in_acc, out_acc, out_free;
    logic       issue_scan, issue_rel, scan_fin, rel_fin, take_byte;
    logic       wr_en, rd_en, scan_clear;
    t_cnt       wr_addr, rd_addr;
    logic [7:0] rd_data;
    t_scan_res  scan_res;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;
    assign out_free   = !r_out_valid || out_acc;

    assign take_byte  = !r_end_seen && (i_in_data_byte != 8'd0) && (r_fill < FILL_MAX);
    assign issue_scan = (r_state == S_SCAN) && (r_idx != r_fill) && !scan_res.mark;
    assign scan_fin   = !issue_scan && !r_rd_vld;
    // A read is only issued when the output register will be free as it lands.
    assign issue_rel  = (r_state == S_REL) && (r_idx != r_len) && !r_rd_vld && out_free;
    assign rel_fin    = (r_idx == r_len) && !r_rd_vld;

    assign wr_en      = in_acc && take_byte
                        && (i_in_command == CMD_BYTE || i_in_command == CMD_BYTE_END);
    assign wr_addr    = addr_add(r_head, r_fill);
    assign rd_en      = issue_scan || issue_rel;
    assign rd_addr    = addr_add(r_head, r_idx);
    assign scan_clear = (r_state == S_IDLE) && (n_state == S_SCAN);

    tss_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_data_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tss_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (scan_clear),
        .i_vld   (r_rd_vld && (r_state == S_SCAN)),
        .i_pos   (r_rd_pos),
        .i_data  (rd_data),
        .i_fill  (r_fill),
        .o_res   (scan_res)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_command)
                        CMD_BYTE_END, CMD_CHUNK_END: begin
                            n_state = r_end_seen ? S_IDLE : S_SCAN;
                        end
                        CMD_EOS: begin
                            if (r_fill != '0) begin
                                n_state = S_REL;
                            end else if (!r_end_seen) begin
                                n_state = S_DONE;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_fin) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (scan_res.len != '0) begin
                    n_state = S_REL;
                end else if (scan_res.mark) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_REL: begin
                if (rel_fin) begin
                    n_state = r_done_after ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_head       = r_head;
        n_fill       = r_fill;
        n_end_seen   = r_end_seen;
        n_idx        = r_idx;
        n_len        = r_len;
        n_done_after = r_done_after;
        n_keep       = r_keep;
        n_rd_vld     = rd_en;
        n_rd_last    = r_rd_last;
        n_rd_pos     = r_rd_pos;
        n_out_valid  = r_out_valid && !out_acc;
        n_out_kind   = r_out_kind;
        n_out_byte   = r_out_byte;
        n_out_seg    = r_out_seg;
        n_out_run    = r_out_run;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (in_acc) begin
                    case (i_in_command)
                        CMD_BYTE, CMD_BYTE_END: begin
                            if (take_byte) begin
                                n_fill = r_fill + t_cnt'(1);
                            end
                        end
                        CMD_EOS: begin
                            n_len        = r_fill;
                            n_done_after = !r_end_seen;
                            n_keep       = 1'b0;
                            n_fill       = '0;
                            n_end_seen   = 1'b0;
                        end
                        CMD_DISCARD: begin
                            n_fill     = '0;
                            n_end_seen = 1'b0;
                        end
                        default: n_fill = r_fill;
                    endcase
                end
            end
            S_SCAN: begin
                if (issue_scan) begin
                    n_rd_pos = r_idx;
                    n_idx    = r_idx + t_cnt'(1);
                end
            end
            S_DECIDE: begin
                n_idx        = '0;
                n_len        = scan_res.len;
                n_done_after = scan_res.mark;
                n_keep       = !scan_res.mark;
                if (scan_res.mark) begin
                    n_fill     = '0;
                    n_end_seen = 1'b1;
                end
            end
            S_REL: begin
                if (issue_rel) begin
                    n_rd_last = ((r_idx + t_cnt'(1)) == r_len);
                    n_idx     = r_idx + t_cnt'(1);
                end
                if (r_rd_vld) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = 1'b0;
                    n_out_byte  = rd_data;
                    n_out_seg   = r_rd_last;
                    n_out_run   = r_rd_last && !r_done_after;
                end
                if (rel_fin) begin
                    n_head = addr_add(r_head, r_len);
                    if (r_keep) begin
                        n_fill = r_fill - r_len;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = 1'b1;
                    n_out_byte  = 8'd0;
                    n_out_seg   = 1'b0;
                    n_out_run   = 1'b1;
                end
            end
            default: n_idx = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_end_seen  <= 1'b0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_end_seen  <= n_end_seen;
            r_idx       <= n_idx;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len        <= n_len;
        r_done_after <= n_done_after;
        r_keep       <= n_keep;
        r_rd_last    <= n_rd_last;
        r_rd_pos     <= n_rd_pos;
        r_out_kind   <= n_out_kind;
        r_out_byte   <= n_out_byte;
        r_out_seg    <= n_out_seg;
        r_out_run    <= n_out_run;
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_kind         = r_out_kind;
    assign o_out_text_byte    = r_out_byte;
    assign o_out_segment_last = r_out_seg;
    assign o_out_run_last     = r_out_run;

    // A released byte landing from the store always finds the output free.
    a_out_free_on_land: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REL && r_rd_vld) |-> out_free)
        else $error("released byte would overwrite a pending word");

    // Once the marker is seen the store stays empty.
    a_empty_after_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_end_seen) |-> (r_fill == '0))
        else $error("store holds text after the end marker");

    // The store never exceeds its capacity.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("fill level beyond store capacity");

    // The release counter never runs past the segment length.
    a_rel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REL) |-> (r_idx <= r_len))
        else $error("release index beyond segment length");

endmodule

`default_nettype wire

@@ rtl/tss_store.sv @@
// Text store: one write port and one registered read port.
// Depends on tss_pkg for the depth and address type.
`timescale 1ns / 1ps
`default_nettype none

module tss_store (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire tss_pkg::t_cnt i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire tss_pkg::t_cnt i_rd_addr,
    output logic [7:0]         o_rd_data
);
    import tss_pkg::*;

    logic [7:0] r_mem [0:BUF_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/tss_scan.sv @@
// Scan tracker: watches the bytes read out of the store in order and finds
// the marker, the last unclosed '<' and the safe release length.
// Depends on tss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tss_scan (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_clear,
    input  wire logic          i_vld,
    input  wire tss_pkg::t_cnt i_pos,
    input  wire logic [7:0]    i_data,
    input  wire tss_pkg::t_cnt i_fill,
    output tss_pkg::t_scan_res o_res
);
    import tss_pkg::*;

    // Index 0 is the newest byte.
    logic [3:0][7:0] r_win, n_win, r_open_win, n_open_win;
    logic [2:0]      r_wcnt, n_wcnt, r_open_wcnt, n_open_wcnt;
    logic            r_open, n_open, r_mark, n_mark;
    t_cnt            r_open_pos, n_open_pos, r_mark_pos, n_mark_pos;

    logic            hit;
    logic [3:0][7:0] w;
    logic [2:0]      c;
    t_cnt            safe0;
    t_cnt            k;

    assign hit = (r_wcnt == WIN_LEN) && (r_win[3] == CH_BANG) && (r_win[2] == CH_E)
                 && (r_win[1] == CH_N) && (r_win[0] == CH_D) && (i_data == CH_BANG);

    always_comb begin
        n_win       = r_win;
        n_wcnt      = r_wcnt;
        n_open      = r_open;
        n_open_pos  = r_open_pos;
        n_open_win  = r_open_win;
        n_open_wcnt = r_open_wcnt;
        n_mark      = r_mark;
        n_mark_pos  = r_mark_pos;
        if (i_clear) begin
            n_wcnt = 3'd0;
            n_open = 1'b0;
            n_mark = 1'b0;
        end else if (i_vld) begin
            if (hit && !r_mark) begin
                n_mark     = 1'b1;
                n_mark_pos = i_pos - t_cnt'(4);
            end
            if (i_data == CH_LT) begin
                n_open      = 1'b1;
                n_open_pos  = i_pos;
                n_open_win  = r_win;
                n_open_wcnt = r_wcnt;
            end else if (i_data == CH_GT) begin
                n_open = 1'b0;
            end
            n_win = {r_win[2:0], i_data};
            if (r_wcnt != WIN_LEN) begin
                n_wcnt = r_wcnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt <= 3'd0;
            r_open <= 1'b0;
            r_mark <= 1'b0;
        end else begin
            r_wcnt <= n_wcnt;
            r_open <= n_open;
            r_mark <= n_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win       <= n_win;
        r_open_pos  <= n_open_pos;
        r_open_win  <= n_open_win;
        r_open_wcnt <= n_open_wcnt;
        r_mark_pos  <= n_mark_pos;
    end

    // The window count equals min(safe0, 4), so it guards each tail compare.
    always_comb begin
        safe0 = r_open ? r_open_pos : i_fill;
        w     = r_open ? r_open_win : r_win;
        c     = r_open ? r_open_wcnt : r_wcnt;
        k     = '0;
        if (c >= 3'd4 && w[3] == CH_BANG && w[2] == CH_E && w[1] == CH_N && w[0] == CH_D) begin
            k = t_cnt'(4);
        end else if (c >= 3'd3 && w[2] == CH_BANG && w[1] == CH_E && w[0] == CH_N) begin
            k = t_cnt'(3);
        end else if (c >= 3'd2 && w[1] == CH_BANG && w[0] == CH_E) begin
            k = t_cnt'(2);
        end else if (c >= 3'd1 && w[0] == CH_BANG) begin
            k = t_cnt'(1);
        end
        o_res.mark = r_mark;
        o_res.len  = r_mark ? r_mark_pos : (safe0 - k);
    end

endmodule

`default_nettype wire

@@ tb/tb_tag_safe_text_segmenter.sv @@
// Self-checking testbench for the tag-safe text segmenter.
// Depends on tss_pkg and the tag_safe_text_segmenter RTL; nothing else.
`timescale 1ns / 1ps

module tb_tag_safe_text_segmenter;
    import tss_pkg::*;

    localparam int STORE_MAX = BUF_DEPTH - 1;

    // One released word as the block should produce it.
    typedef struct packed {
        logic       kind;
        logic [7:0] text_byte;
        logic       seg_last;
        logic       run_last;
    } t_word;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] in_cmd;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall;
    logic       out_kind;
    logic [7:0] out_text;
    logic       out_seg_last;
    logic       out_run_last;

    tag_safe_text_segmenter dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_in_command       (in_cmd),
        .i_in_data_byte     (in_byte),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_out_kind         (out_kind),
        .o_out_text_byte    (out_text),
        .o_out_segment_last (out_seg_last),
        .o_out_run_last     (out_run_last)
    );

    // The clock runs at 8 ns.
    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Our own copy of the segmenter state.
    logic [7:0] held_text[BUF_DEPTH];
    int         held_count;
    logic       marker_seen;

    t_word      pending_words[$];
    int         mismatch_count;
    int         words_checked;
    int         items_sent;

    // Idle rates, in cycles per hundred, and the long receiver hold-off.
    int         send_gap_pct;
    int         recv_stall_pct;
    int         hold_off_cycles;

    function automatic void queue_word(input logic kind, input logic [7:0] b,
                                       input logic seg_last);
        t_word w;
        w.kind      = kind;
        w.text_byte = b;
        w.seg_last  = seg_last;
        w.run_last  = 1'b0;
        pending_words.push_back(w);
    endfunction

    // Release the first len held bytes as one segment.
    function automatic void release_prefix(input int len);
        for (int i = 0; i < len; i++) begin
            queue_word(1'b0, held_text[i], (i == len - 1));
        end
    endfunction

    function automatic logic marker_at(input int pos, input int len);
        logic [7:0] mark[5];
        mark = '{CH_BANG, CH_E, CH_N, CH_D, CH_BANG};
        for (int j = 0; j < len; j++) begin
            if (held_text[pos + j] != mark[j]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Chunk end: look for the marker, otherwise release the safe prefix.
    function automatic void close_chunk();
        int  safe;
        int  open_pos;
        logic open_found;
        if (marker_seen) begin
            return;
        end
        for (int i = 0; i + 5 <= held_count; i++) begin
            if (marker_at(i, 5)) begin
                release_prefix(i);
                held_count  = 0;
                marker_seen = 1'b1;
                queue_word(1'b1, 8'h00, 1'b0);
                return;
            end
        end
        open_found = 1'b0;
        open_pos   = 0;
        for (int i = 0; i < held_count; i++) begin
            if (held_text[i] == CH_LT) begin
                open_found = 1'b1;
                open_pos   = i;
            end else if (held_text[i] == CH_GT) begin
                open_found = 1'b0;
            end
        end
        safe = open_found ? open_pos : held_count;
        // A tail that could grow into the marker is kept back, longest first.
        for (int k = 4; k >= 1; k--) begin
            if (safe >= k && marker_at(safe - k, k)) begin
                safe -= k;
                break;
            end
        end
        if (safe > 0) begin
            release_prefix(safe);
            for (int i = 0; i < held_count - safe; i++) begin
                held_text[i] = held_text[i + safe];
            end
            held_count -= safe;
        end
    endfunction

    // Predict the words one input word causes and queue them.
    function automatic void predict_segments(input logic [2:0] cmd, input logic [7:0] b);
        int before_len;
        before_len = pending_words.size();
        case (cmd)
            CMD_BYTE, CMD_BYTE_END: begin
                if (!marker_seen && b != 8'h00 && held_count < STORE_MAX) begin
                    held_text[held_count] = b;
                    held_count++;
                end
                if (cmd == CMD_BYTE_END) begin
                    close_chunk();
                end
            end
            CMD_CHUNK_END: close_chunk();
            CMD_EOS: begin
                if (held_count > 0) begin
                    release_prefix(held_count);
                    held_count = 0;
                end
                if (!marker_seen) begin
                    queue_word(1'b1, 8'h00, 1'b0);
                end
                marker_seen = 1'b0;
            end
            CMD_DISCARD: begin
                held_count  = 0;
                marker_seen = 1'b0;
            end
            default: ;
        endcase
        if (pending_words.size() > before_len) begin
            pending_words[pending_words.size() - 1].run_last = 1'b1;
        end
    endfunction

    // Offer one word and wait until the block takes it. The word stays
    // offered after the accepting edge until the next word or an idle
    // cycle replaces it.
    task automatic send_word(input logic [2:0] cmd, input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_byte  <= b;
        predict_segments(cmd, b);
        items_sent++;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    task automatic send_text(input string s, input logic end_chunk);
        for (int i = 0; i < s.len(); i++) begin
            send_word((end_chunk && i == s.len() - 1) ? CMD_BYTE_END : CMD_BYTE, s[i]);
        end
    endtask

    // Wait until every predicted word has come back, then a little more.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_words.size() != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    // Receiver stall: random rate, or a long hold-off when one is asked for.
    always @(posedge clk) begin
        if (hold_off_cycles > 0) begin
            out_stall       <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare every accepted word with the oldest prediction.
    always @(posedge clk) begin
        t_word got;
        t_word want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{out_kind, out_text, out_seg_last, out_run_last};
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected word: kind %0d byte %h seg %0d run %0d",
                             got.kind, got.text_byte, got.seg_last, got.run_last);
                end
            end else begin
                want = pending_words.pop_front();
                words_checked++;
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected kind %0d byte %h seg %0d run %0d,",
                                 want.kind, want.text_byte, want.seg_last, want.run_last);
                        $display("          got kind %0d byte %h seg %0d run %0d",
                                 got.kind, got.text_byte, got.seg_last, got.run_last);
                    end
                end
            end
        end
    end

    // Directed cases: markers, open tags, partial marker tails, edge bytes.
    task automatic test_directed();
        send_text("Hi <b>x", 1'b1);          // closed tag, whole chunk goes out
        send_text("a<q", 1'b1);              // open tag holds back "<q"
        send_word(CMD_BYTE_END, 8'h3E);      // closing '>' frees it
        send_text("z!EN", 1'b1);             // tail that starts the marker is kept
        send_word(CMD_BYTE, 8'h00);          // zero byte is never stored
        send_text("D!", 1'b0);
        send_word(CMD_CHUNK_END, 8'hFF);     // marker completes: done word only, no text precedes it
        send_word(CMD_BYTE_END, 8'hFF);      // ignored after the marker
        send_word(CMD_EOS, 8'h00);           // no done word, marker already seen
        send_word(CMD_EOS, 8'h01);           // empty end of stream still gives done
        send_word(3'd5, 8'hAA);              // unused commands do nothing
        send_word(3'd7, 8'h55);
        send_word(CMD_BYTE, 8'h80);
        send_word(CMD_DISCARD, 8'h01);
        send_word(CMD_CHUNK_END, 8'h00);
        wait_drained();
    endtask

    // Overfill the store so bytes are dropped, then flush it.
    task automatic test_full_store();
        for (int i = 0; i < BUF_DEPTH + 2; i++) begin
            send_word(CMD_BYTE, (i == 0) ? 8'h3C : 8'h41 + 8'(i % 26));
        end
        send_word(CMD_BYTE_END, 8'h7A);      // dropped, but the chunk end counts
        send_word(CMD_EOS, 8'h00);
        wait_drained();
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] pool[8];
        pool = '{CH_BANG, CH_E, CH_N, CH_D, CH_LT, CH_GT, 8'h61, 8'h20};
        if ($urandom_range(3) == 0) begin
            return 8'($urandom_range(255));
        end
        return pool[$urandom_range(7)];
    endfunction

    // Random streams: mostly text chunks with marker pieces, some noise.
    task automatic test_random(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 3) begin
                send_text("!END!", 1'($urandom_range(1)));
            end else if (r < 65) begin
                send_word(CMD_BYTE, pick_char());
            end else if (r < 80) begin
                send_word(CMD_BYTE_END, pick_char());
            end else if (r < 86) begin
                send_word(CMD_CHUNK_END, 8'($urandom_range(255)));
            end else if (r < 92) begin
                send_word(CMD_EOS, 8'($urandom_range(255)));
            end else if (r < 96) begin
                send_word(CMD_DISCARD, 8'($urandom_range(255)));
            end else begin
                send_word(3'($urandom_range(7, 5)), 8'($urandom_range(255)));
            end
        end
        send_word(CMD_EOS, 8'h00);
        wait_drained();
    endtask

    // Long receiver hold-off while the sender keeps offering chunks.
    task automatic test_backpressure();
        hold_off_cycles = 400;
        for (int n = 0; n < 3; n++) begin
            send_text("abc>", 1'b1);
        end
        send_word(CMD_EOS, 8'h00);
        wait_drained();
    endtask

    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_cmd         = CMD_BYTE;
        in_byte        = 8'h00;
        out_stall      = 1'b0;
        held_count     = 0;
        marker_seen    = 1'b0;
        mismatch_count = 0;
        words_checked  = 0;
        items_sent     = 0;
        hold_off_cycles = 0;
        send_gap_pct   = 7;
        recv_stall_pct = 77;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_store();
        test_random(20);
        send_gap_pct   = 77;
        recv_stall_pct = 7;
        test_random(20);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random(20);
        test_backpressure();

        $display("Covered %0d input words and %0d released words: markers, open tags,",
                 items_sent, words_checked);
        $display("partial marker tails, a full store, discards and a long output hold-off.");
        if (mismatch_count == 0 && pending_words.size() == 0) begin
            $display("tag_safe_text_segmenter test passed");
        end else begin
            $display("tag_safe_text_segmenter test failed");
        end
        $finish;
    end

    // Safety net against a hung handshake.
    initial begin
        #20ms;
        $display("tag_safe_text_segmenter test failed");
        $finish;
    end

endmodule
